// ===== hw/rtl/model_matrix_transform_composer_assert.svh =====
// Assertion macros used by the checker of the matrix composer.
`ifndef MODEL_MATRIX_TRANSFORM_COMPOSER_ASSERT_SVH
`define MODEL_MATRIX_TRANSFORM_COMPOSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define MMTC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MMTC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mmtc_pkg.sv =====
// Types, codes and constants of the model matrix composer.
package mmtc_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic [2:0] KIND_IDENTITY  = 3'd0;
    localparam logic [2:0] KIND_SCALE     = 3'd1;
    localparam logic [2:0] KIND_ROTATE    = 3'd2;
    localparam logic [2:0] KIND_TRANSLATE = 3'd3;
    localparam logic [2:0] KIND_ORTHO     = 3'd4;

    // 2*pi with 59 fraction bits, pi and pi/2 and CORDIC gain in Q30
    localparam logic [63:0]        TWO_PI_Q59  = 64'h3243F6A8885A308D;
    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] GAIN_Q30    = 36'sd652032874;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] first_arg;
        logic signed [31:0] second_arg;
        logic signed [31:0] third_arg;
        logic signed [31:0] fourth_arg;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         row;
        logic [1:0]         col;
        logic signed [31:0] value;
        logic               divide_error;
        logic               last;
    } t_out_item;

    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/model_matrix_transform_composer.sv =====
// Top level of the model matrix composer: 4x4 fixed-point matrix with 2D transforms.
// The 4x4 matrix sits in a 16-entry memory and is loaded with identity by a fill after
// reset, during which no transaction is taken. One transaction is worked at a time:
// identity rewrites all 16 entries; scale and translate read each row, form two new column
// entries with one shared 32x32 multiplier and write them back; rotate first reduces the
// angle, one restoring step per cycle, then runs CORDIC_STEPS CORDIC iterations (at most
// 30) before the multiply pass; ortho runs four 32-step divisions and a fill.
// The 16 result entries then leave row by row through the memory read port, held while the
// output stalls. A new transaction is taken while the last entry still waits at the output.
module model_matrix_transform_composer #(
    parameter int FRAC_BITS    = mmtc_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = mmtc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mmtc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mmtc_pkg::t_out_item o_out_data
);

    localparam int RW     = 61;
    localparam int ZW     = 36;
    localparam int AW     = 67;
    localparam int S      = 30 - FRAC_BITS;
    localparam int CSTEPS = (CORDIC_STEPS < 30) ? CORDIC_STEPS : 30;
    localparam int KSTEPS = (FRAC_BITS < 30) ? 30 - FRAC_BITS : 1;
    localparam int DW     = (FRAC_BITS + 34 > 65) ? FRAC_BITS + 34 : 65;

    localparam logic [63:0] PERIOD64 =
        (mmtc_pkg::TWO_PI_Q59 + (64'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS);
    localparam logic [RW-1:0] PERIOD    = PERIOD64[RW-1:0];
    localparam logic [RW-1:0] PMOD_INIT = PERIOD << (KSTEPS - 1);
    localparam logic [RW-1:0] RND3      = RW'(1) << (FRAC_BITS - 3);
    localparam logic signed [ZW-1:0] XRND = (S > 0) ? (ZW'(1) << ((S > 0) ? S - 1 : 0)) : '0;
    localparam logic signed [AW-1:0] MRND = AW'(1) << (FRAC_BITS - 1);
    localparam logic signed [31:0]   ONE  = 32'sh1 << FRAC_BITS;

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_FILL = 15'b000000000000010,
        S_RD   = 15'b000000000000100,
        S_MUL  = 15'b000000000001000,
        S_ACC  = 15'b000000000010000,
        S_WB   = 15'b000000000100000,
        S_RED  = 15'b000000001000000,
        S_RFIN = 15'b000000010000000,
        S_CSET = 15'b000000100000000,
        S_CORD = 15'b000001000000000,
        S_CFIN = 15'b000010000000000,
        S_DSET = 15'b000100000000000,
        S_DIV  = 15'b001000000000000,
        S_DSTO = 15'b010000000000000,
        S_EMIT = 15'b100000000000000
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] v);
        logic signed [31:0] r;
        if (v > AW'(32'sh7FFFFFFF)) begin
            r = 32'sh7FFFFFFF;
        end else if (v < AW'(32'sh80000000)) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    t_state r_state, n_state;

    logic [31:0]        r_mem [16];
    logic [31:0]        r_rd_data;
    logic               mem_we;
    logic [3:0]         mem_waddr;
    logic [3:0]         mem_raddr;
    logic [31:0]        mem_wdata;

    logic [2:0]         r_kind;
    logic signed [31:0] r_a0, r_a1, r_a2, r_a3;
    logic               r_err;
    logic               r_emit;
    logic               r_fill_ortho;
    logic               r_pend;
    logic [4:0]         r_cnt;
    logic [1:0]         r_row;

    logic signed [31:0] r_buf [4];
    logic signed [63:0] r_prod;
    logic signed [AW-1:0] r_acc;

    logic [RW-1:0]      r_rem, r_pmod;
    logic               r_aneg;
    logic signed [ZW-1:0] r_x, r_y, r_z;
    logic               r_neg;
    logic signed [31:0] r_c, r_s, r_ns;

    logic [1:0]         r_didx;
    logic [32:0]        r_drem;
    logic [31:0]        r_dlow;
    logic [32:0]        r_dud;
    logic               r_dneg, r_dsat;
    logic signed [31:0] r_q [4];

    logic               r_out_valid;
    mmtc_pkg::t_out_item r_out;

    logic               in_take;
    logic               in_zero;
    logic [31:0]        a0_mag;
    logic               emit_issue;
    logic [1:0]         k_idx;
    logic               j_idx;
    logic signed [31:0] t_val;
    logic signed [63:0] prod;
    logic [31:0]        fill_val;
    logic signed [31:0] wb_val;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_take     = i_in_valid && !o_in_stall;
    assign in_zero     = (i_in_data.second_arg == i_in_data.first_arg) ||
                         (i_in_data.fourth_arg == i_in_data.third_arg);
    assign a0_mag      = i_in_data.first_arg[31] ? 32'(-i_in_data.first_arg)
                                                 : i_in_data.first_arg;
    assign emit_issue  = !r_pend && (!r_out_valid || !i_out_stall);
    assign k_idx       = r_cnt[1:0];
    assign j_idx       = r_cnt[2];
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Column entry of the transform for the current row product
    always_comb begin
        t_val = (k_idx == {1'b0, j_idx}) ? ONE : 32'sh0;
        if (r_kind == mmtc_pkg::KIND_SCALE) begin
            if (k_idx == 2'd0 && !j_idx) t_val = r_a0;
            if (k_idx == 2'd1 && j_idx)  t_val = r_a1;
        end else if (r_kind == mmtc_pkg::KIND_ROTATE) begin
            if (k_idx == 2'd0) t_val = j_idx ? r_s : r_c;
            if (k_idx == 2'd1) t_val = j_idx ? r_c : r_ns;
        end else if (r_kind == mmtc_pkg::KIND_TRANSLATE) begin
            if (k_idx == 2'd3) t_val = j_idx ? r_a1 : r_a0;
        end
    end

    assign prod   = r_buf[k_idx] * t_val;
    assign wb_val = sat32((r_acc + MRND) >>> FRAC_BITS);

    always_comb begin
        fill_val = 32'h0;
        if (r_fill_ortho) begin
            unique case (r_cnt[3:0])
                4'd0:    fill_val = r_q[0];
                4'd12:   fill_val = r_q[1];
                4'd5:    fill_val = r_q[2];
                4'd13:   fill_val = r_q[3];
                4'd10:   fill_val = -ONE;
                4'd15:   fill_val = ONE;
                default: fill_val = 32'h0;
            endcase
        end else if (r_cnt[3:0] == 4'd0 || r_cnt[3:0] == 4'd5 ||
                     r_cnt[3:0] == 4'd10 || r_cnt[3:0] == 4'd15) begin
            fill_val = ONE;
        end
    end

    assign mem_we    = (r_state == S_FILL) || (r_state == S_WB);
    assign mem_waddr = (r_state == S_FILL) ? r_cnt[3:0] : {r_row, 1'b0, j_idx};
    assign mem_wdata = (r_state == S_FILL) ? fill_val : wb_val;
    assign mem_raddr = (r_state == S_RD) ? {r_row, r_cnt[1:0]} : r_cnt[3:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    unique case (i_in_data.kind)
                        mmtc_pkg::KIND_IDENTITY:  n_state = S_FILL;
                        mmtc_pkg::KIND_SCALE:     n_state = S_RD;
                        mmtc_pkg::KIND_TRANSLATE: n_state = S_RD;
                        mmtc_pkg::KIND_ROTATE:    n_state = S_RED;
                        mmtc_pkg::KIND_ORTHO:     n_state = in_zero ? S_EMIT : S_DSET;
                        default:                  n_state = S_EMIT;
                    endcase
                end
            end
            S_FILL: if (r_cnt == 5'd15) n_state = r_emit ? S_EMIT : S_IDLE;
            S_RD:   if (r_cnt == 5'd4) n_state = S_MUL;
            S_MUL:  n_state = S_ACC;
            S_ACC:  n_state = (k_idx == 2'd3) ? S_WB : S_MUL;
            S_WB: begin
                if (!j_idx) begin
                    n_state = S_MUL;
                end else begin
                    n_state = (r_row == 2'd3) ? S_EMIT : S_RD;
                end
            end
            S_RED:  if (r_cnt == 5'(KSTEPS - 1)) n_state = S_RFIN;
            S_RFIN: n_state = S_CSET;
            S_CSET: n_state = S_CORD;
            S_CORD: if (r_cnt == 5'(CSTEPS - 1)) n_state = S_CFIN;
            S_CFIN: n_state = S_RD;
            S_DSET: n_state = S_DIV;
            S_DIV:  if (r_cnt == 5'd31) n_state = S_DSTO;
            S_DSTO: n_state = (r_didx == 2'd3) ? S_FILL : S_DSET;
            S_EMIT: if (r_pend && r_cnt == 5'd15) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath of every state
    always_ff @(posedge i_clk) begin
        logic signed [ZW-1:0] zt, xf, yf, xr, yr, dxs, dys, at;
        logic signed [31:0]   sv;
        logic signed [32:0]   d, sm;
        logic [32:0]          ud, sabs;
        logic [DW-1:0]        un, unp;
        logic [33:0]          rem2;
        logic                 ge, big, ng;
        if (!i_rst_n) begin
            r_state      <= S_FILL;
            r_cnt        <= '0;
            r_fill_ortho <= 1'b0;
            r_emit       <= 1'b0;
            r_pend       <= 1'b0;
            r_err        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_kind       <= i_in_data.kind;
                        r_a0         <= i_in_data.first_arg;
                        r_a1         <= i_in_data.second_arg;
                        r_a2         <= i_in_data.third_arg;
                        r_a3         <= i_in_data.fourth_arg;
                        r_err        <= (i_in_data.kind == mmtc_pkg::KIND_ORTHO) && in_zero;
                        r_cnt        <= '0;
                        r_row        <= '0;
                        r_didx       <= '0;
                        r_fill_ortho <= 1'b0;
                        r_emit       <= 1'b1;
                        r_pend       <= 1'b0;
                        r_aneg       <= i_in_data.first_arg[31];
                        r_rem        <= RW'(a0_mag) << 28;
                        r_pmod       <= PMOD_INIT;
                    end
                end
                S_FILL: r_cnt <= (r_cnt == 5'd15) ? 5'd0 : r_cnt + 5'd1;
                S_RD: begin
                    if (r_cnt != 5'd0) begin
                        r_buf[r_cnt[1:0] - 2'd1] <= r_rd_data;
                    end
                    r_acc <= '0;
                    r_cnt <= (r_cnt == 5'd4) ? 5'd0 : r_cnt + 5'd1;
                end
                S_MUL: r_prod <= prod;
                S_ACC: begin
                    r_acc <= r_acc + AW'(r_prod);
                    if (k_idx != 2'd3) r_cnt <= r_cnt + 5'd1;
                end
                S_WB: begin
                    r_acc <= '0;
                    if (!j_idx) begin
                        r_cnt <= 5'd4;
                    end else begin
                        r_cnt <= 5'd0;
                        r_row <= r_row + 2'd1;
                    end
                end
                S_RED: begin
                    if (r_rem >= r_pmod) r_rem <= r_rem - r_pmod;
                    r_pmod <= r_pmod >> 1;
                    r_cnt  <= (r_cnt == 5'(KSTEPS - 1)) ? 5'd0 : r_cnt + 5'd1;
                end
                S_RFIN: begin
                    // floor modulo for a negative angle
                    if (r_aneg && r_rem != '0) r_rem <= PERIOD - r_rem;
                end
                S_CSET: begin
                    zt = $signed({1'b0, 35'((r_rem + RND3) >> (FRAC_BITS - 2))});
                    if (zt > mmtc_pkg::PI_Q30) zt = zt - (mmtc_pkg::PI_Q30 <<< 1);
                    ng = 1'b0;
                    if (zt > mmtc_pkg::HALF_PI_Q30) begin
                        zt = zt - mmtc_pkg::PI_Q30;
                        ng = 1'b1;
                    end else if (zt < -mmtc_pkg::HALF_PI_Q30) begin
                        zt = zt + mmtc_pkg::PI_Q30;
                        ng = 1'b1;
                    end
                    r_neg <= ng;
                    r_z   <= zt;
                    r_x   <= mmtc_pkg::GAIN_Q30;
                    r_y   <= '0;
                    r_cnt <= '0;
                end
                S_CORD: begin
                    dxs = r_y >>> r_cnt;
                    dys = r_x >>> r_cnt;
                    at  = $signed({4'b0, mmtc_pkg::atan_q30(r_cnt)});
                    if (!r_z[ZW-1]) begin
                        r_x <= r_x - dxs;
                        r_y <= r_y + dys;
                        r_z <= r_z - at;
                    end else begin
                        r_x <= r_x + dxs;
                        r_y <= r_y - dys;
                        r_z <= r_z + at;
                    end
                    r_cnt <= (r_cnt == 5'(CSTEPS - 1)) ? 5'd0 : r_cnt + 5'd1;
                end
                S_CFIN: begin
                    xf = r_neg ? -r_x : r_x;
                    yf = r_neg ? -r_y : r_y;
                    xr = (xf + XRND) >>> S;
                    yr = (yf + XRND) >>> S;
                    sv = sat32(AW'(yr));
                    r_c   <= sat32(AW'(xr));
                    r_s   <= sv;
                    r_ns  <= (sv == 32'sh80000000) ? 32'sh7FFFFFFF : -sv;
                    r_row <= '0;
                    r_cnt <= '0;
                end
                S_DSET: begin
                    d    = r_didx[1] ? (33'(r_a3) - 33'(r_a2)) : (33'(r_a1) - 33'(r_a0));
                    sm   = r_didx[1] ? (33'(r_a3) + 33'(r_a2)) : (33'(r_a1) + 33'(r_a0));
                    ud   = d[32] ? 33'(-d) : 33'(d);
                    sabs = sm[32] ? 33'(-sm) : 33'(sm);
                    un   = r_didx[0] ? (DW'(sabs) << FRAC_BITS) : (DW'(1) << (2 * FRAC_BITS + 1));
                    unp  = un + DW'(ud >> 1);
                    r_dsat <= unp >= (DW'(ud) << 32);
                    r_drem <= unp[64:32];
                    r_dlow <= unp[31:0];
                    r_dud  <= ud;
                    r_dneg <= r_didx[0] ? ((!sm[32] && sm != '0) ^ d[32]) : d[32];
                    r_cnt  <= '0;
                end
                S_DIV: begin
                    // shift quotient bits into the low word as dividend bits leave it
                    rem2 = {r_drem, r_dlow[31]};
                    ge   = rem2 >= {1'b0, r_dud};
                    r_drem <= ge ? 33'(rem2 - {1'b0, r_dud}) : rem2[32:0];
                    r_dlow <= {r_dlow[30:0], ge};
                    r_cnt  <= r_cnt + 5'd1;
                end
                S_DSTO: begin
                    big = r_dsat || r_dlow[31];
                    if (r_dneg) begin
                        r_q[r_didx] <= big ? 32'sh80000000 : -$signed(r_dlow);
                    end else begin
                        r_q[r_didx] <= big ? 32'sh7FFFFFFF : $signed(r_dlow);
                    end
                    if (r_didx == 2'd3) begin
                        r_cnt        <= '0;
                        r_fill_ortho <= 1'b1;
                    end
                    r_didx <= r_didx + 2'd1;
                end
                S_EMIT: begin
                    if (r_pend) begin
                        r_pend <= 1'b0;
                        r_cnt  <= (r_cnt == 5'd15) ? 5'd0 : r_cnt + 5'd1;
                    end else if (emit_issue) begin
                        r_pend <= 1'b1;
                    end
                end
                default: r_cnt <= '0;
            endcase

            // Output register: load on returning read data, drop when taken
            if (r_state == S_EMIT && r_pend) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && r_pend) begin
            r_out.row          <= r_cnt[3:2];
            r_out.col          <= r_cnt[1:0];
            r_out.value        <= r_rd_data;
            r_out.divide_error <= r_err;
            r_out.last         <= (r_cnt == 5'd15);
        end
    end

endmodule

// ===== hw/rtl/mmtc_checker.sv =====
// Port-level checks of the model matrix composer, bound to its top level.
`include "model_matrix_transform_composer_assert.svh"

module mmtc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input mmtc_pkg::t_out_item o_out_data
);

    `MMTC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result transaction changed")
    `MMTC_ASSERT_NOW(a_last_pos, o_out_valid, o_out_data.last == (o_out_data.row == 2'd3 && o_out_data.col == 2'd3), "last flag not on final entry")
    `MMTC_ASSERT_NOW(a_busy_emit, o_out_valid && !o_out_data.last, o_in_stall, "input taken mid-matrix")
    `MMTC_ASSERT_NEXT(a_err_steady, o_out_valid && !i_out_stall && !o_out_data.last, !o_out_valid || $stable(o_out_data.divide_error), "divide error changed within one matrix")

endmodule

bind model_matrix_transform_composer mmtc_checker u_mmtc_checker (.*);

// ===== tb/tb.sv =====
// Testbench for the model matrix composer: directed and random transforms checked against a predictor.
`timescale 1ns / 1ps

module tb;

    localparam int  FRAC      = mmtc_pkg::FRAC_BITS_DEF;
    localparam int  STEPS     = mmtc_pkg::CORDIC_STEPS_DEF;
    localparam int  IDLE_LIMIT = 20000;
    localparam logic [2:0] KIND_BAD5 = 3'd5;
    localparam logic [2:0] KIND_BAD6 = 3'd6;
    localparam logic [2:0] KIND_BAD7 = 3'd7;
    localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;
    localparam logic signed [31:0] PI_Q  = 32'sh0003_243F;
    localparam logic signed [31:0] MAXV  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MINV  = 32'sh8000_0000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    mmtc_pkg::t_in_item  i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    mmtc_pkg::t_out_item o_out_data;

    model_matrix_transform_composer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    logic signed [31:0]  model_mat [16];
    mmtc_pkg::t_out_item entry_queue [$];
    int                  err_count;
    int                  quiet_cycles;
    bit                  idling_on;
    bit                  accepted;
    int                  stall_left;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // ---------------- predictor ----------------
    function automatic logic signed [31:0] sat32(input longint v);
        if (v > longint'(MAXV)) return MAXV;
        if (v < longint'(MINV)) return MINV;
        return v[31:0];
    endfunction

    function automatic void load_identity(ref logic signed [31:0] m [16]);
        for (int i = 0; i < 16; i++)
            m[i] = (i % 5 == 0) ? ONE_Q : 32'sd0;
    endfunction

    function automatic void post_multiply(input logic signed [31:0] t [16]);
        logic signed [31:0] res [16];
        longint hi, lo, p, h;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                hi = 0;
                lo = 0;
                for (int k = 0; k < 4; k++) begin
                    p  = longint'(model_mat[i*4+k]) * longint'(t[k*4+j]);
                    h  = p >>> FRAC;
                    hi += h;
                    lo += p - (h <<< FRAC);
                end
                lo += longint'(1) <<< (FRAC - 1);
                res[i*4+j] = sat32(hi + (lo >>> FRAC));
            end
        end
        model_mat = res;
    endfunction

    function automatic void cordic_sin_cos(input logic signed [31:0] ang,
                                           output logic signed [31:0] sn,
                                           output logic signed [31:0] cs);
        longint period, a, r, z, x, y, dx, dy;
        bit     flip;
        period = longint'((mmtc_pkg::TWO_PI_Q59 + (64'd1 << (30 - FRAC))) >> (31 - FRAC));
        a = longint'(ang) * (longint'(1) <<< 28);
        r = a % period;
        flip = 1'b0;
        if (r < 0) r += period;
        z = (r + (longint'(1) <<< (FRAC - 3))) >>> (FRAC - 2);
        if (z > longint'(mmtc_pkg::PI_Q30)) z -= 2 * longint'(mmtc_pkg::PI_Q30);
        if (z > longint'(mmtc_pkg::HALF_PI_Q30)) begin
            z -= longint'(mmtc_pkg::PI_Q30);
            flip = 1'b1;
        end else if (z < -longint'(mmtc_pkg::HALF_PI_Q30)) begin
            z += longint'(mmtc_pkg::PI_Q30);
            flip = 1'b1;
        end
        x = longint'(mmtc_pkg::GAIN_Q30);
        y = 0;
        for (int i = 0; i < STEPS && i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(mmtc_pkg::atan_q30(i[4:0]));
            end else begin
                x += dx; y -= dy; z += longint'(mmtc_pkg::atan_q30(i[4:0]));
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        cs = sat32((x + (longint'(1) <<< (29 - FRAC))) >>> (30 - FRAC));
        sn = sat32((y + (longint'(1) <<< (29 - FRAC))) >>> (30 - FRAC));
    endfunction

    function automatic logic signed [31:0] div_round(input longint n, input longint d);
        bit                neg;
        longint unsigned   un, ud, q;
        neg = (n < 0) != (d < 0);
        un  = (n < 0) ? longint'(-n) : n;
        ud  = (d < 0) ? longint'(-d) : d;
        q   = (un + ud / 2) / ud;
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        return sat32(neg ? -longint'(q) : longint'(q));
    endfunction

    // Work out the matrix after one transaction and queue its 16 entries.
    function automatic void predict_entries(input mmtc_pkg::t_in_item it);
        logic signed [31:0] t [16];
        logic signed [31:0] sn, cs;
        longint  a0, a1, a2, a3, one, dx, dy;
        bit      div_err;
        mmtc_pkg::t_out_item e;
        a0 = it.first_arg;
        a1 = it.second_arg;
        a2 = it.third_arg;
        a3 = it.fourth_arg;
        one = longint'(1) <<< FRAC;
        div_err = 1'b0;
        load_identity(t);
        case (it.kind)
            mmtc_pkg::KIND_IDENTITY: load_identity(model_mat);
            mmtc_pkg::KIND_SCALE: begin
                t[0] = it.first_arg;
                t[5] = it.second_arg;
                post_multiply(t);
            end
            mmtc_pkg::KIND_ROTATE: begin
                cordic_sin_cos(it.first_arg, sn, cs);
                t[0] = cs;
                t[1] = sn;
                t[4] = sat32(-longint'(sn));
                t[5] = cs;
                post_multiply(t);
            end
            mmtc_pkg::KIND_TRANSLATE: begin
                t[12] = it.first_arg;
                t[13] = it.second_arg;
                post_multiply(t);
            end
            mmtc_pkg::KIND_ORTHO: begin
                dx = a1 - a0;
                dy = a3 - a2;
                if (dx == 0 || dy == 0) begin
                    div_err = 1'b1;
                end else begin
                    t[0]  = div_round(2 * one * one, dx);
                    t[12] = div_round(-(a1 + a0) * one, dx);
                    t[5]  = div_round(2 * one * one, dy);
                    t[13] = div_round(-(a3 + a2) * one, dy);
                    t[10] = -ONE_Q;
                    t[15] = ONE_Q;
                    model_mat = t;
                end
            end
            default: ;
        endcase
        for (int i = 0; i < 16; i++) begin
            e.row          = i[3:2];
            e.col          = i[1:0];
            e.value        = model_mat[i];
            e.divide_error = div_err;
            e.last         = (i == 15);
            entry_queue.push_back(e);
        end
    endfunction

    // ---------------- driving ----------------
    task automatic send_item(input logic [2:0] kind, input logic signed [31:0] a0,
                             input logic signed [31:0] a1, input logic signed [31:0] a2,
                             input logic signed [31:0] a3);
        mmtc_pkg::t_in_item it;
        it.kind       = kind;
        it.first_arg  = a0;
        it.second_arg = a1;
        it.third_arg  = a2;
        it.fourth_arg = a3;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        accepted = 1'b1;
        predict_entries(it);
    endtask

    function automatic logic signed [31:0] any_arg();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? MAXV : MINV;
            2:       return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
            3:       return $signed($urandom_range(0, 2 << 16)) - (1 << 16);
            default: return $signed($urandom_range(0, 1 << 17)) - (1 << 16) + ONE_Q;
        endcase
    endfunction

    // Output side: random stall bursts while idling is on.
    always @(posedge i_clk) begin
        if (!i_rst_n || !idling_on) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= (stall_left > 1);
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left  <= $urandom_range(1, 15);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Compare each emitted entry with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            accepted = 1'b1;
            if (entry_queue.size() == 0) begin
                $display("%0t: unexpected entry, expected none, actual %p", $realtime, o_out_data);
                err_count++;
            end else begin
                mmtc_pkg::t_out_item e;
                e = entry_queue.pop_front();
                if (o_out_data.row !== e.row || o_out_data.col !== e.col) begin
                    $display("%0t: position mismatch, expected %0d,%0d actual %0d,%0d",
                             $realtime, e.row, e.col, o_out_data.row, o_out_data.col);
                    err_count++;
                end
                if (o_out_data.value !== e.value) begin
                    $display("%0t: value mismatch at %0d,%0d, expected %h actual %h",
                             $realtime, e.row, e.col, e.value, o_out_data.value);
                    err_count++;
                end
                if (o_out_data.divide_error !== e.divide_error) begin
                    $display("%0t: divide_error mismatch, expected %b actual %b",
                             $realtime, e.divide_error, o_out_data.divide_error);
                    err_count++;
                end
                if (o_out_data.last !== e.last) begin
                    $display("%0t: last mismatch, expected %b actual %b",
                             $realtime, e.last, o_out_data.last);
                    err_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side.
    always @(posedge i_clk) begin
        if (accepted) quiet_cycles <= 0;
        else          quiet_cycles <= quiet_cycles + 1;
        accepted = 1'b0;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------- tests ----------------
    task automatic test_directed();
        send_item(mmtc_pkg::KIND_IDENTITY, 0, 0, 0, 0);
        send_item(mmtc_pkg::KIND_SCALE, ONE_Q, ONE_Q, 0, 0);
        send_item(mmtc_pkg::KIND_SCALE, 2 * ONE_Q, -3 * ONE_Q, MAXV, MINV);
        send_item(mmtc_pkg::KIND_SCALE, MAXV, MINV, 0, 0);
        send_item(mmtc_pkg::KIND_SCALE, 0, 0, 0, 0);
        send_item(mmtc_pkg::KIND_IDENTITY, MAXV, MINV, MAXV, MINV);
        send_item(mmtc_pkg::KIND_ROTATE, 0, 0, 0, 0);
        send_item(mmtc_pkg::KIND_ROTATE, PI_Q, 0, 0, 0);
        send_item(mmtc_pkg::KIND_ROTATE, -PI_Q, 0, 0, 0);
        send_item(mmtc_pkg::KIND_ROTATE, PI_Q / 2, 0, 0, 0);
        send_item(mmtc_pkg::KIND_ROTATE, MAXV, 0, 0, 0);
        send_item(mmtc_pkg::KIND_ROTATE, MINV, 0, 0, 0);
        send_item(mmtc_pkg::KIND_TRANSLATE, 5 * ONE_Q, -7 * ONE_Q, 0, 0);
        send_item(mmtc_pkg::KIND_TRANSLATE, MAXV, MINV, 0, 0);
        send_item(mmtc_pkg::KIND_ORTHO, -ONE_Q, ONE_Q, -ONE_Q, ONE_Q);
        send_item(mmtc_pkg::KIND_ORTHO, 3 * ONE_Q, 3 * ONE_Q, 0, ONE_Q);
        send_item(mmtc_pkg::KIND_ORTHO, 0, ONE_Q, 2 * ONE_Q, 2 * ONE_Q);
        send_item(mmtc_pkg::KIND_ORTHO, MINV, MAXV, MAXV, MINV);
        send_item(mmtc_pkg::KIND_ORTHO, 0, 1, -1, 0);
        send_item(KIND_BAD5, MAXV, MAXV, MAXV, MAXV);
        send_item(KIND_BAD6, 0, 0, 0, 0);
        send_item(KIND_BAD7, MINV, MINV, MINV, MINV);
        send_item(mmtc_pkg::KIND_IDENTITY, 0, 0, 0, 0);
    endtask

    task automatic test_random(input int count);
        logic [2:0]         kind;
        logic signed [31:0] l, b;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 19) == 0 ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            if (kind == mmtc_pkg::KIND_ORTHO && $urandom_range(0, 2) != 0) begin
                // mostly sensible ranges, sometimes a zero width or height
                l = any_arg();
                b = any_arg();
                send_item(kind, l, $urandom_range(0, 7) == 0 ? l : l + any_arg(),
                          b, $urandom_range(0, 7) == 0 ? b : b + any_arg());
            end else begin
                send_item(kind, any_arg(), any_arg(), $urandom, $urandom);
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        err_count   = 0;
        quiet_cycles = 0;
        accepted    = 1'b0;
        idling_on   = 1'b1;
        load_identity(model_mat);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(270);
        idling_on = 1'b0;
        test_random(40);
        i_in_valid <= 1'b0;
        while (entry_queue.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
